### hdl/lei_pkg.sv
// Shared types and constants for the log-energy table interpolator.
package lei_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int RES_W    = 48;
    localparam int LOG_W    = 32;
    localparam int FRAC_BITS = 26;
    localparam int F_W      = 32;
    localparam int F_SHIFT  = 24;
    localparam int DIFF_W   = 33;
    localparam int NUM_W    = 56;
    localparam int PROD_W   = 65;
    localparam int LANES    = 3;

    localparam int S_TDATA_W = 4 * WORD_W;
    localparam int M_TDATA_W = WORD_W + LANES * RES_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

endpackage

### hdl/lei_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module lei_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/log_energy_table_interpolator.sv
// Log-energy table interpolator: table in RAM, linear search, log2, divide, interpolate.
// Clear and append beats finish in the idle state. A query scans the entries, fetches the
// bracketing pair, runs three logs through the serial log2 unit, then the bit-serial divider
// (skipped when the logs are equal) and the shared multiplier, and accepts one beat at a time.
// A miss skips the log2, divider and multiplier steps.
// Reset clears the entry count; the RAMs are not cleared.
module log_energy_table_interpolator #(
    parameter int TABLE_DEPTH = lei_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // energy, value_a, value_b, value_c (32 bits each)
    input  logic [lei_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [lei_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_energy (32), out_a, out_b, out_c (48 bits each)
    output logic [lei_pkg::M_TDATA_W-1:0] m_tdata,
    // hit
    output logic                          m_tuser
);

    import lei_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W  = LANES * WORD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_FETCH_WAIT,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DIV_FIX,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        scan_reg;
    logic [CNT_W-1:0]        cmp_idx_reg;
    logic                    cmp_vld_reg;
    logic [ADDR_W-1:0]       found_reg;
    logic                    hit_reg;
    logic [WORD_W-1:0]       eq_reg;
    logic [WORD_W-1:0]       elo_reg;
    logic [WORD_W-1:0]       ehi_reg;
    logic [VAL_W-1:0]        vlo_reg;
    logic [VAL_W-1:0]        vhi_reg;
    logic [1:0]              sel_reg;
    logic [WORD_W-1:0]       m_reg;
    logic [4:0]              top_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [4:0]              k_reg;
    logic signed [LOG_W-1:0] lq_reg;
    logic signed [LOG_W-1:0] l0_reg;
    logic signed [LOG_W-1:0] l1_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DIFF_W-2:0]       dmag_reg;
    logic [DIFF_W-1:0]       rem_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic [5:0]              dcnt_reg;
    logic signed [F_W-1:0]   f_reg;
    logic [1:0]              lane_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [LANES*RES_W-1:0]  res_reg;
    logic                    mvalid_reg;
    logic [M_TDATA_W-1:0]    mdata_reg;
    logic                    muser_reg;

    logic                    in_fire;
    kind_t                   in_kind;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]       e_rdata;
    logic [VAL_W-1:0]        v_rdata;
    logic [2*WORD_W-1:0]     sq;
    logic [WORD_W:0]         sq_sh;
    logic signed [LOG_W-1:0] log_res;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] den;
    logic [DIFF_W-1:0]       rem_sh;
    logic [WORD_W-1:0]       lane_lo;
    logic [WORD_W-1:0]       lane_hi;
    logic signed [DIFF_W-1:0] lane_d;
    logic signed [RES_W-1:0] lane_res;
    logic                    out_free;

    assign in_kind   = kind_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign ram_we    = in_fire && (in_kind == KIND_APPEND) && (cnt_reg < CNT_W'(TABLE_DEPTH));
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;
    assign out_free  = !mvalid_reg || m_tready;

    always_comb
    begin
        unique case (state_reg)
            ST_SEARCH:   ram_raddr = scan_reg[ADDR_W-1:0];
            ST_FETCH_LO: ram_raddr = found_reg - ADDR_W'(1);
            default:     ram_raddr = found_reg;
        endcase
    end

    lei_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_energy_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata[WORD_W-1:0]),
        .raddr (ram_raddr),
        .rdata (e_rdata)
    );

    lei_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata[S_TDATA_W-1:WORD_W]),
        .raddr (ram_raddr),
        .rdata (v_rdata)
    );

    // Log2 unit: normalize one bit per cycle, then one squaring per fraction bit.
    assign sq       = {WORD_W'(0), m_reg} * {WORD_W'(0), m_reg};
    assign sq_sh    = sq[2*WORD_W-1:WORD_W-1];
    assign log_res  = {{2{~top_reg[4]}}, top_reg[3:0], frac_reg[FRAC_BITS-2:0], sq_sh[WORD_W]};

    assign diff   = DIFF_W'(lq_reg) - DIFF_W'(l0_reg);
    assign den    = DIFF_W'(l1_reg) - DIFF_W'(l0_reg);
    assign rem_sh = {rem_reg[DIFF_W-2:0], num_reg[NUM_W-1]};

    assign lane_lo  = vlo_reg[lane_reg*WORD_W +: WORD_W];
    assign lane_hi  = vhi_reg[lane_reg*WORD_W +: WORD_W];
    assign lane_d   = $signed({1'b0, lane_hi}) - $signed({1'b0, lane_lo});
    // The shifted product stays within 41 bits, so the sum never reaches the 48-bit limits.
    assign lane_res = $signed({{(RES_W-WORD_W){1'b0}}, lane_lo})
                    + RES_W'($signed(prod_reg[PROD_W-1:F_SHIFT]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            scan_reg    <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= '0;
            hit_reg     <= 1'b0;
            eq_reg      <= '0;
            elo_reg     <= '0;
            ehi_reg     <= '0;
            vlo_reg     <= '0;
            vhi_reg     <= '0;
            sel_reg     <= '0;
            m_reg       <= '0;
            top_reg     <= '0;
            frac_reg    <= '0;
            k_reg       <= '0;
            lq_reg      <= '0;
            l0_reg      <= '0;
            l1_reg      <= '0;
            num_reg     <= '0;
            dmag_reg    <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            neg_reg     <= 1'b0;
            dcnt_reg    <= '0;
            f_reg       <= '0;
            lane_reg    <= '0;
            prod_reg    <= '0;
            res_reg     <= '0;
            mvalid_reg  <= 1'b0;
            mdata_reg   <= '0;
            muser_reg   <= 1'b0;
        end
        else
        begin
            // In ST_DONE the output register is reloaded below instead.
            if (mvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                mvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        eq_reg <= s_tdata[WORD_W-1:0];
                        unique case (in_kind)
                            KIND_CLEAR:
                            begin
                                cnt_reg <= '0;
                            end
                            KIND_APPEND:
                            begin
                                if (ram_we)
                                begin
                                    cnt_reg <= cnt_reg + CNT_W'(1);
                                end
                            end
                            KIND_QUERY:
                            begin
                                hit_reg     <= 1'b0;
                                scan_reg    <= CNT_W'(1);
                                cmp_vld_reg <= 1'b0;
                                if (cnt_reg < CNT_W'(2))
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_SEARCH;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // One address issued per cycle; each compare happens in the cycle after its address is issued.
                ST_SEARCH:
                begin
                    scan_reg    <= scan_reg + CNT_W'(1);
                    cmp_idx_reg <= scan_reg;
                    cmp_vld_reg <= 1'b1;
                    if (cmp_vld_reg)
                    begin
                        if (e_rdata >= eq_reg)
                        begin
                            hit_reg   <= 1'b1;
                            found_reg <= cmp_idx_reg[ADDR_W-1:0];
                            ehi_reg   <= e_rdata;
                            state_reg <= ST_FETCH_LO;
                        end
                        else if (cmp_idx_reg == cnt_reg - CNT_W'(1))
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end

                ST_FETCH_LO:
                begin
                    state_reg <= ST_FETCH_HI;
                end

                ST_FETCH_HI:
                begin
                    elo_reg   <= e_rdata;
                    vlo_reg   <= v_rdata;
                    state_reg <= ST_FETCH_WAIT;
                end

                ST_FETCH_WAIT:
                begin
                    vhi_reg   <= v_rdata;
                    sel_reg   <= 2'd0;
                    m_reg     <= (eq_reg == '0) ? WORD_W'(1) : eq_reg;
                    top_reg   <= 5'd31;
                    state_reg <= ST_LOG_NORM;
                end

                ST_LOG_NORM:
                begin
                    if (m_reg[WORD_W-1])
                    begin
                        k_reg     <= '0;
                        frac_reg  <= '0;
                        state_reg <= ST_LOG_SQ;
                    end
                    else
                    begin
                        m_reg   <= {m_reg[WORD_W-2:0], 1'b0};
                        top_reg <= top_reg - 5'd1;
                    end
                end

                ST_LOG_SQ:
                begin
                    if (k_reg != 5'(FRAC_BITS - 1))
                    begin
                        m_reg <= sq_sh[WORD_W] ? sq_sh[WORD_W:1] : sq_sh[WORD_W-1:0];
                    end
                    frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_sh[WORD_W]};
                    k_reg    <= k_reg + 5'd1;
                    if (k_reg == 5'(FRAC_BITS - 1))
                    begin
                        case (sel_reg)
                            2'd0:    lq_reg <= log_res;
                            2'd1:    l0_reg <= log_res;
                            default: l1_reg <= log_res;
                        endcase
                        if (sel_reg == 2'd2)
                        begin
                            state_reg <= ST_DIV_SETUP;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 2'd1;
                            top_reg   <= 5'd31;
                            state_reg <= ST_LOG_NORM;
                            // The next operand is loaded in the same cycle the selector moves.
                            m_reg     <= (sel_reg == 2'd0)
                                       ? ((elo_reg == '0) ? WORD_W'(1) : elo_reg)
                                       : ((ehi_reg == '0) ? WORD_W'(1) : ehi_reg);
                        end
                    end
                end

                ST_DIV_SETUP:
                begin
                    lane_reg <= '0;
                    if (den == '0)
                    begin
                        f_reg     <= '0;
                        state_reg <= ST_LERP_MUL;
                    end
                    else
                    begin
                        num_reg   <= {(diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff)),
                                      {(NUM_W-DIFF_W){1'b0}}} << 1;
                        dmag_reg  <= den[DIFF_W-1] ? 32'(-den) : 32'(den);
                        neg_reg   <= diff[DIFF_W-1] ^ den[DIFF_W-1];
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end

                // Restoring division, one quotient bit per cycle.
                ST_DIV:
                begin
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (rem_sh >= {1'b0, dmag_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, dmag_reg};
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    if (dcnt_reg == 6'(NUM_W - 1))
                    begin
                        state_reg <= ST_DIV_FIX;
                    end
                end

                ST_DIV_FIX:
                begin
                    if (!neg_reg)
                    begin
                        f_reg <= (quo_reg > NUM_W'(32'h7FFF_FFFF))
                               ? F_W'(32'h7FFF_FFFF) : F_W'(quo_reg);
                    end
                    else
                    begin
                        f_reg <= (quo_reg > NUM_W'(32'h8000_0000))
                               ? F_W'(32'h8000_0000) : F_W'(-quo_reg);
                    end
                    state_reg <= ST_LERP_MUL;
                end

                ST_LERP_MUL:
                begin
                    prod_reg  <= PROD_W'(lane_d) * PROD_W'(f_reg);
                    state_reg <= ST_LERP_ADD;
                end

                ST_LERP_ADD:
                begin
                    res_reg[lane_reg*RES_W +: RES_W] <= lane_res;
                    if (lane_reg == 2'(LANES - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + 2'd1;
                        state_reg <= ST_LERP_MUL;
                    end
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        mvalid_reg <= 1'b1;
                        muser_reg  <= hit_reg;
                        mdata_reg  <= hit_reg ? {res_reg, eq_reg} : '0;
                        state_reg  <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
